// ===== design/mpeg_audio_frame_header_decoder_defines.svh =====
// Assertion macros shared by the frame header decoder modules.
`ifndef MPEG_AUDIO_FRAME_HEADER_DECODER_DEFINES_SVH
`define MPEG_AUDIO_FRAME_HEADER_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MPAHD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpahd assertion failed");

// Next-cycle implication, checked out of reset.
`define MPAHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpahd assertion failed");

`endif

// ===== design/mpahd_pkg.sv =====
// Types, constants and lookup tables for the MPEG audio frame header decoder.
`default_nettype none

package mpahd_pkg;

    // Version codes as reported on the result
    localparam logic [1:0] VER_MPEG1  = 2'd0;
    localparam logic [1:0] VER_MPEG2  = 2'd1;
    localparam logic [1:0] VER_MPEG25 = 2'd2;

    // Layer numbers
    localparam logic [1:0] LAYER_1 = 2'd1;
    localparam logic [1:0] LAYER_2 = 2'd2;
    localparam logic [1:0] LAYER_3 = 2'd3;

    localparam logic [7:0]  SYNC_BYTE      = 8'hFF;
    localparam logic [7:0]  SYNC_B1_MIN    = 8'd224;
    localparam logic [11:0] MAX_FRAME_LEN  = 12'd2880;

    localparam logic [10:0] SPF_L1   = 11'd384;
    localparam logic [10:0] SPF_FULL = 11'd1152;
    localparam logic [10:0] SPF_LSF  = 11'd576;

    localparam logic [5:0] XOFF_V1_STEREO  = 6'd32;
    localparam logic [5:0] XOFF_MID        = 6'd17;
    localparam logic [5:0] XOFF_LSF_MONO   = 6'd9;

    // Length factor times 40: sr = base * 2^shift and base = 25 * divisor,
    // so K*br*1000/sr = ((K*40)*br / divisor) >> shift.
    localparam logic [12:0] LEN_MULT_L1     = 13'd480;
    localparam logic [12:0] LEN_MULT_L3_LSF = 13'd2880;
    localparam logic [12:0] LEN_MULT_STD    = 13'd5760;

    // Reciprocal scale; numerator stays below 2^RECIP_SHIFT
    localparam int RECIP_SHIFT = 22;
    localparam int NUM_W       = 22;
    localparam int QUOT_W      = 13;
    localparam int REM_W       = 10;

    localparam logic [8:0] KBPS_V1_L1 [16] = '{
        9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
    localparam logic [8:0] KBPS_V1_L2 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam logic [8:0] KBPS_V1_L3 [16] = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam logic [8:0] KBPS_V2_L1 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
    localparam logic [8:0] KBPS_V2_L23 [16] = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

    // Decoded header carried down the pipeline
    typedef struct packed {
        logic        ok;
        logic [1:0]  version_code;
        logic [1:0]  layer;
        logic [8:0]  bitrate_kbps;
        logic [15:0] sample_rate_hz;
        logic        is_stereo;
        logic        has_padding;
        logic        crc_present;
        logic [10:0] frame_samples;
        logic [5:0]  side_info_len;
        logic [1:0]  sr_index;
        logic [1:0]  rate_shift;
        logic [12:0] len_mult;
    } hdr_info_t;

    // Uncorrected quotient and remainder from the reciprocal divider
    typedef struct packed {
        logic [QUOT_W-1:0] quot;
        logic [REM_W-1:0]  rem;
    } len_part_t;

    function automatic logic [8:0] kbps_lookup(input logic [2:0] row, input logic [3:0] idx);
        logic [8:0] val;
        unique case (row)
            3'd0:    val = KBPS_V1_L1[idx];
            3'd1:    val = KBPS_V1_L2[idx];
            3'd2:    val = KBPS_V1_L3[idx];
            3'd3:    val = KBPS_V2_L1[idx];
            default: val = KBPS_V2_L23[idx];
        endcase
        return val;
    endfunction

    // Lowest sample rate of each column (MPEG-2.5); higher versions shift left
    function automatic logic [13:0] sr_base(input logic [1:0] sri);
        logic [13:0] val;
        unique case (sri)
            2'd0:    val = 14'd11025;
            2'd1:    val = 14'd12000;
            2'd2:    val = 14'd8000;
            default: val = 14'd0;
        endcase
        return val;
    endfunction

    // sr_base / 25
    function automatic logic [8:0] div_base(input logic [1:0] sri);
        logic [8:0] val;
        unique case (sri)
            2'd1:    val = 9'd480;
            2'd2:    val = 9'd320;
            default: val = 9'd441;
        endcase
        return val;
    endfunction

    // floor(2^RECIP_SHIFT / div_base)
    function automatic logic [13:0] recip(input logic [1:0] sri);
        logic [13:0] val;
        unique case (sri)
            2'd1:    val = 14'd8738;
            2'd2:    val = 14'd13107;
            default: val = 14'd9510;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== design/mpahd_decode.sv =====
// Stage 1: header field checks, table lookups and length factor selection.
`default_nettype none

module mpahd_decode (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [31:0]        header_word,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mpahd_pkg::hdr_info_t    info
);

    localparam logic [1:0] VBITS_MPEG1    = 2'b11;
    localparam logic [1:0] VBITS_MPEG2    = 2'b10;
    localparam logic [1:0] VBITS_RESERVED = 2'b01;
    localparam logic [1:0] LBITS_RESERVED = 2'b00;
    localparam logic [3:0] BRI_FREE       = 4'd0;
    localparam logic [3:0] BRI_BAD        = 4'd15;
    localparam logic [1:0] SRI_RESERVED   = 2'd3;
    localparam logic [1:0] CHMODE_MONO    = 2'd3;

    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [1:0]  vbits;
    logic [1:0]  lbits;
    logic [3:0]  bri;
    logic [1:0]  sri;
    logic [1:0]  vcode;
    logic [1:0]  layer_num;
    logic [2:0]  row;
    logic [1:0]  shift;
    logic        stereo;
    mpahd_pkg::hdr_info_t info_next;
    mpahd_pkg::hdr_info_t info_reg;
    logic        valid_reg;

    always_comb
    begin
        b0    = header_word[31:24];
        b1    = header_word[23:16];
        b2    = header_word[15:8];
        b3    = header_word[7:0];
        vbits = b1[4:3];
        lbits = b1[2:1];
        bri   = b2[7:4];
        sri   = b2[3:2];

        unique case (vbits)
            VBITS_MPEG1: vcode = mpahd_pkg::VER_MPEG1;
            VBITS_MPEG2: vcode = mpahd_pkg::VER_MPEG2;
            default:     vcode = mpahd_pkg::VER_MPEG25;
        endcase
        layer_num = 2'(3'd4 - {1'b0, lbits});
        shift     = 2'(2'd2 - vcode);

        if (vcode == mpahd_pkg::VER_MPEG1)
        begin
            row = 3'({1'b0, layer_num} - 3'd1);
        end
        else
        begin
            row = (layer_num == mpahd_pkg::LAYER_1) ? 3'd3 : 3'd4;
        end

        stereo = (b3[7:6] != CHMODE_MONO);

        info_next.ok = (b0 == mpahd_pkg::SYNC_BYTE) && (b1 >= mpahd_pkg::SYNC_B1_MIN)
                    && (vbits != VBITS_RESERVED) && (lbits != LBITS_RESERVED)
                    && (bri != BRI_FREE) && (bri != BRI_BAD) && (sri != SRI_RESERVED);
        info_next.version_code   = vcode;
        info_next.layer          = layer_num;
        info_next.bitrate_kbps   = mpahd_pkg::kbps_lookup(row, bri);
        info_next.sample_rate_hz = 16'({2'b00, mpahd_pkg::sr_base(sri)} << shift);
        info_next.is_stereo      = stereo;
        info_next.has_padding    = b2[1];
        info_next.crc_present    = ~b1[0];
        info_next.sr_index       = sri;
        info_next.rate_shift     = shift;

        priority if (layer_num == mpahd_pkg::LAYER_1)
        begin
            info_next.frame_samples = mpahd_pkg::SPF_L1;
        end
        else if (layer_num == mpahd_pkg::LAYER_2 || vcode == mpahd_pkg::VER_MPEG1)
        begin
            info_next.frame_samples = mpahd_pkg::SPF_FULL;
        end
        else
        begin
            info_next.frame_samples = mpahd_pkg::SPF_LSF;
        end

        if (vcode == mpahd_pkg::VER_MPEG1)
        begin
            info_next.side_info_len = stereo ? mpahd_pkg::XOFF_V1_STEREO : mpahd_pkg::XOFF_MID;
        end
        else
        begin
            info_next.side_info_len = stereo ? mpahd_pkg::XOFF_MID : mpahd_pkg::XOFF_LSF_MONO;
        end

        priority if (layer_num == mpahd_pkg::LAYER_1)
        begin
            info_next.len_mult = mpahd_pkg::LEN_MULT_L1;
        end
        else if (layer_num == mpahd_pkg::LAYER_3 && vcode != mpahd_pkg::VER_MPEG1)
        begin
            info_next.len_mult = mpahd_pkg::LEN_MULT_L3_LSF;
        end
        else
        begin
            info_next.len_mult = mpahd_pkg::LEN_MULT_STD;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            info_reg <= info_next;
        end
    end

    assign out_valid = valid_reg;
    assign info      = info_reg;

endmodule

`default_nettype wire

// ===== design/mpahd_div.sv =====
// Stages 2-4: numerator product, reciprocal multiply and remainder.
`default_nettype none

`include "mpeg_audio_frame_header_decoder_defines.svh"

module mpahd_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mpahd_pkg::hdr_info_t in_info,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mpahd_pkg::hdr_info_t    out_info,
    output mpahd_pkg::len_part_t    part
);

    localparam int NW   = mpahd_pkg::NUM_W;
    localparam int QW   = mpahd_pkg::QUOT_W;
    localparam int RW   = mpahd_pkg::REM_W;
    localparam int RS   = mpahd_pkg::RECIP_SHIFT;
    localparam int PW   = NW + 14;

    logic                 v2_reg;
    logic                 v3_reg;
    logic                 v4_reg;
    logic                 rdy2;
    logic                 rdy3;
    logic                 rdy4;
    mpahd_pkg::hdr_info_t info2_reg;
    mpahd_pkg::hdr_info_t info3_reg;
    mpahd_pkg::hdr_info_t info4_reg;
    logic [NW-1:0]        num2_next;
    logic [NW-1:0]        num2_reg;
    logic [NW-1:0]        num3_reg;
    logic [PW-1:0]        prod3;
    logic [QW-1:0]        quot3_next;
    logic [QW-1:0]        quot3_reg;
    logic [NW-1:0]        back4;
    logic [NW-1:0]        diff4;
    mpahd_pkg::len_part_t part4_next;
    mpahd_pkg::len_part_t part4_reg;
    logic [RW-1:0]        rem_limit;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = rdy2;

    // bitrate * (K*40) fits in NW bits for any 9 x 13 bit operands
    assign num2_next = NW'(in_info.bitrate_kbps) * NW'(in_info.len_mult);

    // floor estimate, low by at most one
    assign prod3      = PW'(num2_reg) * PW'(mpahd_pkg::recip(info2_reg.sr_index));
    assign quot3_next = prod3[RS +: QW];

    assign back4            = NW'(quot3_reg) * NW'(mpahd_pkg::div_base(info3_reg.sr_index));
    assign diff4            = num3_reg - back4;
    assign part4_next.quot  = quot3_reg;
    assign part4_next.rem   = diff4[RW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy2)
            begin
                v2_reg <= in_valid;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && in_valid)
        begin
            info2_reg <= in_info;
            num2_reg  <= num2_next;
        end
        if (rdy3 && v2_reg)
        begin
            info3_reg <= info2_reg;
            num3_reg  <= num2_reg;
            quot3_reg <= quot3_next;
        end
        if (rdy4 && v3_reg)
        begin
            info4_reg <= info3_reg;
            part4_reg <= part4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_info  = info4_reg;
    assign part      = part4_reg;

    assign rem_limit = RW'({mpahd_pkg::div_base(info4_reg.sr_index), 1'b0});

    // the reciprocal estimate never misses by more than one divisor
    `MPAHD_ASSERT_IMPL(a_rem_bound, clk, rst_n, v4_reg, part4_reg.rem < rem_limit)
    `MPAHD_ASSERT_NEXT(a_s2_to_s3, clk, rst_n, v2_reg && rdy3, v3_reg)

endmodule

`default_nettype wire

// ===== design/mpahd_final.sv =====
// Stage 5: quotient correction, frame length, final check and output register.
`default_nettype none

`include "mpeg_audio_frame_header_decoder_defines.svh"

module mpahd_final (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mpahd_pkg::hdr_info_t info,
    input  wire mpahd_pkg::len_part_t part,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    valid_res,
    output logic [1:0]              version_code,
    output logic [1:0]              layer,
    output logic [8:0]              bitrate_kbps,
    output logic [15:0]             sample_rate_hz,
    output logic                    is_stereo,
    output logic                    has_padding,
    output logic                    crc_present,
    output logic [10:0]             frame_samples,
    output logic [5:0]              side_info_len,
    output logic [11:0]             frame_bytes
);

    localparam int QW = mpahd_pkg::QUOT_W;
    localparam int LW = QW + 3;

    logic [QW:0]          quot;
    logic [QW:0]          scaled;
    logic [QW:0]          base_len;
    logic [LW-1:0]        len_full;
    logic                 ok;
    logic                 out_valid_reg;
    logic                 valid_res_reg;
    logic [1:0]           version_code_reg;
    logic [1:0]           layer_reg;
    logic [8:0]           bitrate_kbps_reg;
    logic [15:0]          sample_rate_hz_reg;
    logic                 is_stereo_reg;
    logic                 has_padding_reg;
    logic                 crc_present_reg;
    logic [10:0]          frame_samples_reg;
    logic [5:0]           side_info_len_reg;
    logic [11:0]          frame_bytes_reg;

    always_comb
    begin
        quot = {1'b0, part.quot}
             + (QW+1)'(part.rem >= (mpahd_pkg::REM_W)'(mpahd_pkg::div_base(info.sr_index)));
        scaled   = quot >> info.rate_shift;
        base_len = scaled + (QW+1)'(info.has_padding);
        if (info.layer == mpahd_pkg::LAYER_1)
        begin
            len_full = {base_len, 2'b00};
        end
        else
        begin
            len_full = {2'b00, base_len};
        end
        ok = info.ok && (len_full != '0) && (len_full <= LW'(mpahd_pkg::MAX_FRAME_LEN));
    end

    assign in_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // a rejected header reports all fields as zero
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            valid_res_reg      <= ok;
            version_code_reg   <= ok ? info.version_code : '0;
            layer_reg          <= ok ? info.layer : '0;
            bitrate_kbps_reg   <= ok ? info.bitrate_kbps : '0;
            sample_rate_hz_reg <= ok ? info.sample_rate_hz : '0;
            is_stereo_reg      <= ok && info.is_stereo;
            has_padding_reg    <= ok && info.has_padding;
            crc_present_reg    <= ok && info.crc_present;
            frame_samples_reg  <= ok ? info.frame_samples : '0;
            side_info_len_reg  <= ok ? info.side_info_len : '0;
            frame_bytes_reg    <= ok ? len_full[11:0] : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign valid_res      = valid_res_reg;
    assign version_code   = version_code_reg;
    assign layer          = layer_reg;
    assign bitrate_kbps   = bitrate_kbps_reg;
    assign sample_rate_hz = sample_rate_hz_reg;
    assign is_stereo      = is_stereo_reg;
    assign has_padding    = has_padding_reg;
    assign crc_present    = crc_present_reg;
    assign frame_samples  = frame_samples_reg;
    assign side_info_len  = side_info_len_reg;
    assign frame_bytes    = frame_bytes_reg;

    `MPAHD_ASSERT_IMPL(a_len_range, clk, rst_n, out_valid_reg && valid_res_reg,
        (frame_bytes_reg != 12'd0) && (frame_bytes_reg <= mpahd_pkg::MAX_FRAME_LEN))
    `MPAHD_ASSERT_IMPL(a_reject_zero, clk, rst_n, out_valid_reg && !valid_res_reg,
        (bitrate_kbps_reg == 9'd0) && (sample_rate_hz_reg == 16'd0) && (frame_bytes_reg == 12'd0))
    `MPAHD_ASSERT_IMPL(a_spf_layer, clk, rst_n, out_valid_reg && valid_res_reg,
        (layer_reg == mpahd_pkg::LAYER_1) == (frame_samples_reg == mpahd_pkg::SPF_L1))

endmodule

`default_nettype wire

// ===== design/mpeg_audio_frame_header_decoder.sv =====
// MPEG audio frame header decoder, top level.
// Decodes one 32-bit MPEG audio frame header (first byte in bits 31:24) into
// version, layer, bitrate, sample rate, channel, padding and CRC flags,
// samples per frame, Xing tag offset and frame length in bytes; valid_res is
// low and every other field zero when the header fails sync, uses a reserved
// version, layer or sample rate, a free or bad bitrate index, or gives a
// length of zero or above 2880 bytes. The block is a five-stage pipeline
// (decode and tables, numerator product, reciprocal multiply, remainder,
// correction and length check): it takes one header per clock while the
// output is not stalled, and each result is registered through the stages in
// that order before it is presented on the output. The length division by the
// sample rate is a 22x14-bit reciprocal multiply plus a one-step correction,
// which sets the stage split. A stalled output holds every occupied stage;
// empty stages keep filling.
`default_nettype none

module mpeg_audio_frame_header_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] header_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             valid_res,
    output logic [1:0]       version_code,
    output logic [1:0]       layer,
    output logic [8:0]       bitrate_kbps,
    output logic [15:0]      sample_rate_hz,
    output logic             is_stereo,
    output logic             has_padding,
    output logic             crc_present,
    output logic [10:0]      frame_samples,
    output logic [5:0]       side_info_len,
    output logic [11:0]      frame_bytes
);

    logic                 dec_valid;
    logic                 dec_ready;
    mpahd_pkg::hdr_info_t dec_info;
    logic                 div_valid;
    logic                 div_ready;
    mpahd_pkg::hdr_info_t div_info;
    mpahd_pkg::len_part_t div_part;

    mpahd_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .header_word (header_word),
        .out_valid   (dec_valid),
        .out_ready   (dec_ready),
        .info        (dec_info)
    );

    mpahd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_info   (dec_info),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_info  (div_info),
        .part      (div_part)
    );

    mpahd_final u_final (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (div_valid),
        .in_ready       (div_ready),
        .info           (div_info),
        .part           (div_part),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .valid_res      (valid_res),
        .version_code   (version_code),
        .layer          (layer),
        .bitrate_kbps   (bitrate_kbps),
        .sample_rate_hz (sample_rate_hz),
        .is_stereo      (is_stereo),
        .has_padding    (has_padding),
        .crc_present    (crc_present),
        .frame_samples  (frame_samples),
        .side_info_len  (side_info_len),
        .frame_bytes    (frame_bytes)
    );

endmodule

`default_nettype wire
